// File: rtl/nsfc_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence framer and checker.
`default_nettype none
package nsfc_pkg;

    localparam int LENGTH_BITS_DEF = 10;
    localparam int CAP_W           = 10;
    localparam int LIMIT_W         = 6;
    localparam int CFG_DATA_W      = 10;
    localparam int CFG_INDEX_W     = 1;
    localparam int OUT_LEN_W       = 10;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 10'd159;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd24;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_CAPACITY = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LIMIT   = 1'd1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [23:0] TAIL_GGA  = 24'h474741;
    localparam logic [23:0] TAIL_RMC  = 24'h524D43;
    localparam logic [23:0] TAIL_GSA  = 24'h475341;
    localparam logic [31:0] TAIL_PSTI = 32'h50535449;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_GGA   = 3'd1;
    localparam logic [2:0] KIND_RMC   = 3'd2;
    localparam logic [2:0] KIND_GSA   = 3'd3;
    localparam logic [2:0] KIND_PSTI  = 3'd4;

    typedef struct packed {
        logic [1:0]           status;
        logic [2:0]           kind;
        logic [LIMIT_W-1:0]   field_count;
        logic [7:0]           checksum;
        logic [OUT_LEN_W-1:0] line_length;
    } t_result;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/nsfc_frame.sv
// Line state and per-byte result logic of the sentence framer.
`default_nettype none
module nsfc_frame
    import nsfc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic [CAP_W-1:0]   i_line_capacity,
    input  wire logic [LIMIT_W-1:0] i_field_limit,
    output logic                    o_push,
    output t_result                 o_result
);

    localparam int CW      = (LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W;
    localparam int OW      = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;
    localparam int LEN_MAX = (1 << LENGTH_BITS) - 1;

    typedef struct packed {
        logic                   in_line;
        logic [LENGTH_BITS-1:0] held;
        logic [7:0]             xor_acc;
        logic                   star_seen;
        logic [1:0]             digits;
        logic [8:0]             rcv;
        logic                   id_done;
        logic [2:0]             id_len;
        logic [31:0]            id_tail;
        logic [LIMIT_W-1:0]     commas;
    } t_line;

    t_line r_line, n_line;

    logic [CW-1:0]      cap_w;
    logic [CW-1:0]      held_w;
    logic [OW-1:0]      len_w;
    logic [LIMIT_W-1:0] limit_eff;
    logic [LIMIT_W:0]   fc_raw;
    logic [LIMIT_W-1:0] fc;
    logic [4:0]         hv;
    logic               ok;
    logic [2:0]         kind;

    always_comb begin
        cap_w = CW'(i_line_capacity);
        if (cap_w > CW'(LEN_MAX)) begin
            cap_w = CW'(LEN_MAX);
        end
        held_w    = CW'(r_line.held);
        len_w     = OW'(r_line.held);
        limit_eff = (i_field_limit == '0) ? LIMIT_W'(1) : i_field_limit;
        fc_raw    = {1'b0, r_line.commas} + (LIMIT_W+1)'(1);
        fc        = (fc_raw > {1'b0, limit_eff}) ? limit_eff : fc_raw[LIMIT_W-1:0];
        hv        = hex_digit(i_rx_byte);
        ok = r_line.star_seen && r_line.digits == 2'd2 && !r_line.rcv[8] &&
             r_line.rcv[7:0] == r_line.xor_acc;
        kind = KIND_OTHER;
        if (r_line.id_len >= 3'd3 && r_line.id_tail[23:0] == TAIL_GGA) kind = KIND_GGA;
        else if (r_line.id_len >= 3'd3 && r_line.id_tail[23:0] == TAIL_RMC) kind = KIND_RMC;
        else if (r_line.id_len >= 3'd3 && r_line.id_tail[23:0] == TAIL_GSA) kind = KIND_GSA;
        else if (r_line.id_len == 3'd4 && r_line.id_tail == TAIL_PSTI) kind = KIND_PSTI;

        o_result.status      = STATUS_OK;
        o_result.kind        = KIND_OTHER;
        o_result.field_count = fc;
        o_result.checksum    = r_line.xor_acc;
        o_result.line_length = len_w[OUT_LEN_W-1:0];
        o_push = 1'b0;
        n_line = r_line;

        case (i_rx_byte)
            CH_DOLLAR: begin
                n_line         = '0;
                n_line.in_line = 1'b1;
                n_line.held    = LENGTH_BITS'(1);
            end
            CH_CR: begin
            end
            CH_LF: begin
                if (r_line.in_line) begin
                    o_push = 1'b1;
                    if (ok) begin
                        o_result.kind = kind;
                    end else begin
                        o_result.status = STATUS_BAD;
                    end
                    n_line = '0;
                end
            end
            default: begin
                if (r_line.in_line) begin
                    if (held_w >= cap_w) begin
                        o_push          = 1'b1;
                        o_result.status = STATUS_OVERFLOW;
                        n_line          = '0;
                    end else begin
                        n_line.held = r_line.held + LENGTH_BITS'(1);
                        if (!r_line.star_seen) begin
                            if (i_rx_byte == CH_STAR) begin
                                n_line.star_seen = 1'b1;
                                n_line.id_done   = 1'b1;
                            end else begin
                                n_line.xor_acc = r_line.xor_acc ^ i_rx_byte;
                                if (i_rx_byte == CH_COMMA && r_line.commas != '1) begin
                                    n_line.commas = r_line.commas + LIMIT_W'(1);
                                end
                                if (!r_line.id_done) begin
                                    if (i_rx_byte == CH_COMMA && limit_eff >= LIMIT_W'(2)) begin
                                        n_line.id_done = 1'b1;
                                    end else begin
                                        n_line.id_tail = {r_line.id_tail[23:0], i_rx_byte};
                                        if (r_line.id_len != 3'd7) begin
                                            n_line.id_len = r_line.id_len + 3'd1;
                                        end
                                    end
                                end
                            end
                        end else if (r_line.digits != 2'd2) begin
                            n_line.rcv    = {r_line.rcv[8] | hv[4], r_line.rcv[3:0], hv[3:0]};
                            n_line.digits = r_line.digits + 2'd1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else if (i_accept) begin
            r_line <= n_line;
        end
    end

endmodule
`default_nettype wire

// File: rtl/nsfc_outq.sv
// Two-entry result queue: output register plus skid slot.
`default_nettype none
module nsfc_outq
    import nsfc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  t_result      i_result,
    input  wire logic    i_out_stall,
    output logic         o_full,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    pop;

    assign pop      = r_out_v && !i_out_stall;
    assign o_full   = r_skid_v;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (!r_out_v) begin
            r_out_v <= i_push;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_v) begin
            r_out <= r_skid;
        end else if ((pop || !r_out_v) && i_push) begin
            r_out <= i_result;
        end
        if (r_out_v && !pop && i_push) begin
            r_skid <= i_result;
        end
    end

endmodule
`default_nettype wire

// File: rtl/nmea_sentence_framer_checker_top.sv
// Top level of the NMEA sentence framer and checker.
// One received byte is taken every clock cycle while o_rx_stall is low; the line state (length, running XOR,
// checksum digits, sentence id tail, comma count) is updated by combinational next-state logic, and a
// result for a newline or an overflowing byte is registered at the edge that takes the byte
// and offered from the next cycle if no earlier result waits. Results leave through a two-entry queue, so bytes keep
// flowing while one result waits; o_rx_stall rises only when both entries are held.
// Configuration takes effect on the next byte; the user must write it only while idle; the block does not check.
`default_nettype none
module nmea_sentence_framer_checker_top
    import nsfc_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_rx_valid,
    output logic                        o_rx_stall,
    input  wire logic [7:0]             i_rx_byte,
    output logic                        o_res_valid,
    input  wire logic                   i_res_stall,
    output logic [1:0]                  o_status,
    output logic [2:0]                  o_sentence_kind,
    output logic [LIMIT_W-1:0]          o_field_count,
    output logic [7:0]                  o_computed_checksum,
    output logic [OUT_LEN_W-1:0]        o_line_length
);

    logic [CAP_W-1:0]   r_line_capacity;
    logic [LIMIT_W-1:0] r_field_limit;
    logic               accept;
    logic               push;
    logic               full;
    t_result            res_new;
    t_result            res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_capacity <= CAP_RESET;
            r_field_limit   <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_CAPACITY: r_line_capacity <= i_cfg_data[CAP_W-1:0];
                REG_FIELD_LIMIT:   r_field_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_rx_stall = full;
    assign accept     = i_rx_valid && !full;

    nsfc_frame #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_frame (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_line_capacity(r_line_capacity),
        .i_field_limit  (r_field_limit),
        .o_push         (push),
        .o_result       (res_new)
    );

    nsfc_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push && accept),
        .i_result   (res_new),
        .i_out_stall(i_res_stall),
        .o_full     (full),
        .o_valid    (o_res_valid),
        .o_result   (res_out)
    );

    assign o_status            = res_out.status;
    assign o_sentence_kind     = res_out.kind;
    assign o_field_count       = res_out.field_count;
    assign o_computed_checksum = res_out.checksum;
    assign o_line_length       = res_out.line_length;

    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("input stalled with no result pending");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_status != 2'd3)
        else $error("undefined status code");

    a_kind_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != STATUS_OK) |-> o_sentence_kind == KIND_OTHER)
        else $error("sentence kind set on a failed line");

    a_field_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_field_count != '0 &&
                         (o_field_count <= r_field_limit || r_field_limit == '0)))
        else $error("field count out of range");

endmodule
`default_nettype wire

// File: dv/tb_nmea_sentence_framer_checker_top.sv
// Self-checking testbench for the NMEA sentence framer and checker: directed sentences, then random byte streams.
module tb_nmea_sentence_framer_checker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nsfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam string NON_HEX     = "G:g@/Z";

    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_ONE_DIGIT,
        FLAW_NONHEX,
        FLAW_NO_STAR,
        FLAW_TRAILING
    } flaw_e;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   rx_valid    = 1'b0;
    logic                   rx_stall;
    logic [7:0]             rx_byte     = '0;
    logic                   res_valid;
    logic                   res_stall   = 1'b0;
    logic [1:0]             status;
    logic [2:0]             kind;
    logic [LIMIT_W-1:0]     field_count;
    logic [7:0]             checksum;
    logic [OUT_LEN_W-1:0]   line_length;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int idle_cycles    = 0;
    int framed_bytes   = 0;

    t_result    expected_reports[$];
    logic [7:0] body_buf[$];

    // sentence tracker state
    logic [CAP_W-1:0]   cap_q   = CAP_RESET;
    logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;
    logic               ln_active;
    logic [9:0]         ln_len;
    logic [7:0]         ln_xor;
    logic               ln_star;
    logic [1:0]         ln_ndigits;
    logic [8:0]         ln_digits;
    logic               ln_id_done;
    logic [2:0]         ln_id_len;
    logic [31:0]        ln_id_tail;
    logic [5:0]         ln_commas;

    nmea_sentence_framer_checker_top i_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .i_rx_valid          (rx_valid),
        .o_rx_stall          (rx_stall),
        .i_rx_byte           (rx_byte),
        .o_res_valid         (res_valid),
        .i_res_stall         (res_stall),
        .o_status            (status),
        .o_sentence_kind     (kind),
        .o_field_count       (field_count),
        .o_computed_checksum (checksum),
        .o_line_length       (line_length)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic void clear_sentence();
        ln_active  = 1'b0;
        ln_len     = '0;
        ln_xor     = '0;
        ln_star    = 1'b0;
        ln_ndigits = '0;
        ln_digits  = '0;
        ln_id_done = 1'b0;
        ln_id_len  = '0;
        ln_id_tail = '0;
        ln_commas  = '0;
    endfunction

    function automatic logic [5:0] eff_limit();
        return (limit_q == '0) ? 6'd1 : limit_q;
    endfunction

    function automatic void push_report(logic [1:0] st, logic [2:0] kd);
        t_result r;
        logic [6:0] fc;
        fc = 7'(ln_commas) + 7'd1;
        if (fc > 7'(eff_limit())) fc = 7'(eff_limit());
        r.status      = st;
        r.kind        = kd;
        r.field_count = fc[5:0];
        r.checksum    = ln_xor;
        r.line_length = ln_len;
        expected_reports.push_back(r);
    endfunction

    function automatic void track_nmea_byte(logic [7:0] c);
        logic [4:0] nib;
        logic [2:0] kd;
        if (c == CH_DOLLAR || (ln_active && c != CH_CR)) framed_bytes++;
        if (c == CH_DOLLAR) begin
            clear_sentence();
            ln_active = 1'b1;
            ln_len    = 10'd1;
        end else if (c == CH_LF) begin
            if (ln_active) begin
                if (ln_star && ln_ndigits == 2'd2 && !ln_digits[8] &&
                    ln_digits[7:0] == ln_xor) begin
                    kd = KIND_OTHER;
                    if (ln_id_len >= 3 && ln_id_tail[23:0] == TAIL_GGA) kd = KIND_GGA;
                    else if (ln_id_len >= 3 && ln_id_tail[23:0] == TAIL_RMC) kd = KIND_RMC;
                    else if (ln_id_len >= 3 && ln_id_tail[23:0] == TAIL_GSA) kd = KIND_GSA;
                    else if (ln_id_len == 4 && ln_id_tail == TAIL_PSTI) kd = KIND_PSTI;
                    push_report(STATUS_OK, kd);
                end else begin
                    push_report(STATUS_BAD, KIND_OTHER);
                end
                clear_sentence();
            end
        end else if (c != CH_CR && ln_active) begin
            if (ln_len >= cap_q) begin
                push_report(STATUS_OVERFLOW, KIND_OTHER);
                clear_sentence();
            end else begin
                ln_len = ln_len + 10'd1;
                if (!ln_star) begin
                    if (c == CH_STAR) begin
                        ln_star    = 1'b1;
                        ln_id_done = 1'b1;
                    end else begin
                        ln_xor = ln_xor ^ c;
                        if (c == CH_COMMA && ln_commas != 6'd63) ln_commas++;
                        if (!ln_id_done) begin
                            if (c == CH_COMMA && eff_limit() >= 6'd2) begin
                                ln_id_done = 1'b1;
                            end else begin
                                ln_id_tail = {ln_id_tail[23:0], c};
                                if (ln_id_len != 3'd7) ln_id_len++;
                            end
                        end
                    end
                end else if (ln_ndigits != 2'd2) begin
                    nib = 5'h10;
                    if (c inside {[8'h30:8'h39]}) nib = {1'b0, c[3:0]};
                    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) nib = {1'b0, c[3:0] + 4'd9};
                    ln_digits  = {ln_digits[8] | nib[4], ln_digits[3:0], nib[3:0]};
                    ln_ndigits = ln_ndigits + 2'd1;
                end
            end
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_valid && !res_stall) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d length %0d",
                         $time, status, line_length);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("status", want.status, status);
                check_field("sentence_kind", want.kind, kind);
                check_field("field_count", want.field_count, field_count);
                check_field("computed_checksum", want.checksum, checksum);
                check_field("line_length", want.line_length, line_length);
            end
        end
    end

    always @(posedge clk) begin
        if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        track_nmea_byte(b);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        rx_valid = 1'b0;
        while (expected_reports.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_LINE_CAPACITY) cap_q = CAP_W'(val);
        else limit_q = LIMIT_W'(val);
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) body_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'h30 + n;
        return 8'((lower ? 8'h61 : 8'h41) + n - 10);
    endfunction

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        do begin
            case ($urandom_range(9))
                0, 1: c = CH_COMMA;
                2: c = 8'($urandom_range(255));
                3: c = ($urandom_range(3) == 0) ? CH_CR : 8'($urandom_range(255));
                default: c = 8'($urandom_range(8'h20, 8'h7E));
            endcase
        end while (c == CH_DOLLAR || c == CH_STAR || c == CH_LF);
        return c;
    endfunction

    function automatic string pick_id();
        case ($urandom_range(7))
            0: return "GPGGA";
            1: return "GNRMC";
            2: return "GPGSA";
            3: return "PSTI";
            4: return "GGA";
            5: return "XPSTI";
            6: return "PST";
            default: return "GLGSV";
        endcase
    endfunction

    task automatic send_sentence(string body, flaw_e flaw);
        logic [7:0] sum;
        logic [7:0] digits[$];
        bit lower;
        add_text(body);
        sum = '0;
        foreach (body_buf[i]) if (body_buf[i] != CH_CR) sum ^= body_buf[i];
        if (flaw == FLAW_SUM) sum ^= 8'(1 << $urandom_range(7));
        lower = 1'($urandom_range(1));
        send_byte(CH_DOLLAR);
        foreach (body_buf[i]) send_byte(body_buf[i]);
        body_buf.delete();
        if (flaw != FLAW_NO_STAR) begin
            send_byte(CH_STAR);
            digits = '{hex_char(sum[7:4], lower), hex_char(sum[3:0], lower)};
            case (flaw)
                FLAW_ONE_DIGIT: void'(digits.pop_back());
                FLAW_NONHEX: digits[$urandom_range(1)] = NON_HEX[$urandom_range(5)];
                FLAW_TRAILING: begin
                    digits.push_back(CH_COMMA);
                    digits.push_back(8'h5A);
                end
                default: ;
            endcase
            foreach (digits[i]) send_byte(digits[i]);
        end
        if ($urandom_range(1)) send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_random_line();
        int r;
        flaw_e flaw;
        r = $urandom_range(99);
        if (r < 75) begin
            if ($urandom_range(9) < 7) add_text(pick_id());
            else repeat ($urandom_range(8)) body_buf.push_back(random_char());
            repeat ($urandom_range(6)) begin
                body_buf.push_back(CH_COMMA);
                repeat ($urandom_range(5)) body_buf.push_back(random_char());
            end
            flaw = ($urandom_range(4) != 0) ? FLAW_NONE : flaw_e'($urandom_range(1, 5));
            send_sentence("", flaw);
        end else if (r < 90) begin
            send_byte(CH_DOLLAR);
            repeat ($urandom_range(12)) send_byte(random_char());
            case ($urandom_range(2))
                0: send_byte(CH_LF);
                1: send_byte(CH_STAR);
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_sentence_kinds();
        send_sentence("GPGGA,1,2", FLAW_NONE);
        send_sentence("GNRMC,A", FLAW_NONE);
        send_sentence("GPGSA", FLAW_NONE);
        send_sentence("PSTI,030,1", FLAW_NONE);
        send_sentence("XPSTI,1", FLAW_NONE);
        send_sentence("GA,1", FLAW_NONE);
        send_sentence("", FLAW_NONE);
    endtask

    task automatic test_checksum_errors();
        send_sentence("GPGGA,1", FLAW_SUM);
        send_sentence("GPRMC,2", FLAW_ONE_DIGIT);
        send_sentence("GPGSA,3", FLAW_NONHEX);
        send_sentence("PSTI,4", FLAW_NO_STAR);
        send_sentence("GNGGA,5", FLAW_TRAILING);
    endtask

    task automatic test_framing();
        send_byte(CH_LF);
        send_byte(8'h61);
        send_byte(CH_CR);
        add_text("GP");
        body_buf.push_back(CH_CR);
        add_text("RMC,1");
        send_sentence("", FLAW_NONE);
        send_byte(CH_DOLLAR);
        add_text("GPGGA,12");
        foreach (body_buf[i]) send_byte(body_buf[i]);
        body_buf.delete();
        send_sentence("GNGSA", FLAW_NONE);
        add_text("GGA,");
        body_buf.push_back(8'h00);
        body_buf.push_back(8'hFF);
        body_buf.push_back(8'h80);
        send_sentence("", FLAW_NONE);
    endtask

    task automatic test_field_limit();
        write_reg(REG_FIELD_LIMIT, 1);
        send_sentence("GP,GGA,1", FLAW_NONE);
        write_reg(REG_FIELD_LIMIT, 3);
        send_sentence("A,B,C,D,E", FLAW_NONE);
        write_reg(REG_FIELD_LIMIT, 63);
        add_text("GPGSA");
        repeat (70) body_buf.push_back(CH_COMMA);
        send_sentence("", FLAW_NONE);
        write_reg(REG_FIELD_LIMIT, LIMIT_RESET);
    endtask

    task automatic test_overflow();
        write_reg(REG_LINE_CAPACITY, 2);
        send_byte(CH_DOLLAR);
        send_byte(8'h41);
        send_byte(8'h42);
        send_byte(CH_LF);
        send_sentence("GGA", FLAW_NONE);
        write_reg(REG_LINE_CAPACITY, 20);
        send_sentence("GPGGA,1234567890", FLAW_NONE);
        send_sentence("GPGGA,12345678901", FLAW_NONE);
        write_reg(REG_LINE_CAPACITY, 520);
        send_byte(CH_DOLLAR);
        repeat (521) send_byte(8'(8'h41 + $urandom_range(25)));
        send_byte(CH_LF);
        write_reg(REG_LINE_CAPACITY, CAP_RESET);
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, int cap, int limit,
                                       int n_items);
        int target;
        int lines;
        write_reg(REG_LINE_CAPACITY, cap);
        write_reg(REG_FIELD_LIMIT, limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        target = framed_bytes + n_items;
        lines  = 0;
        while (framed_bytes < target) begin
            send_random_line();
            lines++;
            // hold the sender until every result is back
            if (lines % 4 == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        clear_sentence();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_sentence_kinds();
        test_checksum_errors();
        test_framing();
        test_field_limit();
        test_overflow();
        test_random_traffic(0, 0, 159, 24, 100);
        test_random_traffic(49, 0, 40, 3, 100);
        test_random_traffic(0, 49, 1023, 63, 100);
        test_random_traffic(25, 25, 12, 1, 100);
        wait_drained();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
